/* rtl/rolling_odometer_digit_updater_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rolling odometer digit updater.
// Each macro places one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ROLLING_ODOMETER_DIGIT_UPDATER_DEFINES_SVH
`define ROLLING_ODOMETER_DIGIT_UPDATER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ROD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ROD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rod_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_pkg
// Types, constants and helper functions shared by the odometer digit updater.
// ----------------------------------------------------------------------------
package rod_pkg;

  localparam int NUM_PLACES    = 6;
  localparam int DIG_W         = 4;
  localparam int POS_W         = 3;
  localparam int OFF_W         = 5;
  localparam int CNT_W         = 32;
  localparam int FRAC_IN_W     = 8;
  localparam int INVERT_PLACES = 4;

  localparam logic [DIG_W-1:0] DIGIT_BLANK = 4'd15;
  localparam logic [DIG_W-1:0] DIGIT_NINE  = 4'd9;
  localparam logic [DIG_W-1:0] DIGIT_ZERO  = 4'd0;

  // Count modulo one million: q is estimated from count/64 divided by 15625
  // through a reciprocal, which is low by at most one.
  localparam int                 QPROD_W    = 53;
  localparam int                 QUOT_SHIFT = 40;
  localparam int                 QUOT_W     = 13;
  localparam logic [26:0]        QUOT_MUL   = 27'd70368744;
  localparam logic [19:0]        DEC_MOD    = 20'd1000000;
  localparam int                 REM_W      = 20;

  // Digit split: the remainder scaled by 2^37/100000, then one digit per
  // multiply by ten.
  localparam int                 FX_W       = 41;
  localparam int                 FX_FRAC_W  = 37;
  localparam logic [20:0]        FX_MUL     = 21'd1374390;

  localparam logic [FRAC_IN_W-1:0] ROLL_THRESHOLD = 8'd231;
  localparam logic [16:0]          ROLL_BIAS      = 17'd73728;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [CNT_W-1:0]     hundredths_count;
    logic [FRAC_IN_W-1:0] hundredths_fraction;
  } rod_in_t;

  typedef struct packed {
    logic [POS_W-1:0] digit_position;
    logic [DIG_W-1:0] digit_value;
    logic [DIG_W-1:0] next_digit;
    logic [OFF_W-1:0] roll_offset;
    logic             rolling;
    logic             inverted;
    logic             last;
  } rod_out_t;

  // One classified frame: digits by place (0 most significant), roll flags
  // and the roll offset.
  typedef logic [NUM_PLACES-1:0][DIG_W-1:0] rod_digits_t;

  typedef struct packed {
    rod_digits_t             digits;
    logic [NUM_PLACES-1:0]   roll;
    logic [OFF_W-1:0]        offset;
  } rod_item_t;

  // floor((frac*320 - 73728) / 256) for frac at or above the threshold.
  function automatic logic [OFF_W-1:0] roll_offset_of(input logic [FRAC_IN_W-1:0] frac);
    logic [16:0] scaled;
    scaled = ({1'b0, frac, 8'b0}) + ({3'b0, frac, 6'b0}) - ROLL_BIAS;
    if (frac < ROLL_THRESHOLD) begin
      return '0;
    end
    return scaled[12:8];
  endfunction

  function automatic logic [FX_W-1:0] times_ten(input logic [FX_FRAC_W-1:0] x);
    logic [FX_W-1:0] wide;
    wide = FX_W'(x);
    return (wide << 3) + (wide << 1);
  endfunction

endpackage

/* rtl/rod_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_front
// Accepts frames, reduces the count modulo one million, splits it into six
// digits and works out the roll offset and per-place roll flags.
// ----------------------------------------------------------------------------
module rod_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rod_pkg::rod_in_t   in_data,
  output logic               push,
  output rod_pkg::rod_item_t push_data,
  input  logic               full
);
  import rod_pkg::*;

  localparam int NSTG   = 11;
  localparam int LAST   = NSTG - 1;
  localparam int NDSTG  = NUM_PLACES - 1;

  logic [NSTG-1:0]       vld_r;
  logic                  adv;

  logic [CNT_W-1:0]      cnt1_r, cnt2_r, cnt3_r;
  logic [FRAC_IN_W-1:0]  frac1_r;
  logic [QUOT_W-1:0]     qe2_r;
  logic [CNT_W-1:0]      prod3_r;
  logic [REM_W:0]        rem4_r;
  logic [REM_W-1:0]      rem5_r;
  logic [OFF_W-1:0]      off2_r, off3_r, off4_r, off5_r;
  logic [FX_W-1:0]       fx_r  [0:NDSTG];
  rod_digits_t           dg_r  [0:NDSTG];
  logic [OFF_W-1:0]      offs_r [0:NDSTG];

  logic [QPROD_W-1:0]    qprod_nxt;
  logic [32:0]           prod_nxt;
  logic [CNT_W-1:0]      diff_nxt;
  logic [REM_W:0]        rem_nxt;
  logic [FX_W-1:0]       fx_nxt;
  rod_digits_t           digs_fin;
  logic [NUM_PLACES-1:0] roll_fin;

  assign adv      = !(vld_r[LAST] && full);
  assign in_stall = !adv;
  assign push     = vld_r[LAST] && !full;

  assign qprod_nxt = QPROD_W'(cnt1_r[CNT_W-1:6]) * QPROD_W'(QUOT_MUL);
  assign prod_nxt  = 33'(qe2_r) * 33'(DEC_MOD);
  assign diff_nxt  = cnt3_r - prod3_r;
  assign rem_nxt   = (rem4_r >= (REM_W+1)'(DEC_MOD)) ? rem4_r - (REM_W+1)'(DEC_MOD) : rem4_r;
  assign fx_nxt    = FX_W'(rem5_r) * FX_W'(FX_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cnt1_r    <= in_data.hundredths_count;
      frac1_r   <= in_data.hundredths_fraction;
      cnt2_r    <= cnt1_r;
      qe2_r     <= qprod_nxt[QUOT_SHIFT +: QUOT_W];
      off2_r    <= roll_offset_of(frac1_r);
      cnt3_r    <= cnt2_r;
      prod3_r   <= prod_nxt[CNT_W-1:0];
      off3_r    <= off2_r;
      rem4_r    <= diff_nxt[REM_W:0];
      off4_r    <= off3_r;
      rem5_r    <= rem_nxt[REM_W-1:0];
      off5_r    <= off4_r;
      fx_r[0]   <= fx_nxt;
      dg_r[0]   <= '0;
      offs_r[0] <= off5_r;
      for (int j = 1; j <= NDSTG; j++) begin
        fx_r[j]   <= times_ten(fx_r[j-1][FX_FRAC_W-1:0]);
        offs_r[j] <= offs_r[j-1];
        // Stage j fills in place j-1 and carries the places found earlier.
        for (int k = 0; k < NUM_PLACES; k++) begin
          if (k == j - 1) begin
            dg_r[j][k] <= fx_r[j-1][FX_W-1 -: DIG_W];
          end else begin
            dg_r[j][k] <= dg_r[j-1][k];
          end
        end
      end
    end
  end

  // The last digit comes off the final stage; roll flags ripple up from the
  // least significant place while the lower places all show nine.
  always_comb begin
    digs_fin           = dg_r[NDSTG];
    digs_fin[NDSTG]    = fx_r[NDSTG][FX_W-1 -: DIG_W];
    roll_fin[NDSTG]    = (offs_r[NDSTG] != '0);
    for (int i = NDSTG - 1; i >= 0; i--) begin
      roll_fin[i] = roll_fin[i+1] && (digs_fin[i+1] == DIGIT_NINE);
    end
    push_data.digits = digs_fin;
    push_data.roll   = roll_fin;
    push_data.offset = offs_r[NDSTG];
  end

endmodule

/* rtl/rod_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_fifo
// Small register queue of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module rod_fifo #(
  parameter int DEPTH = rod_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rod_pkg::rod_item_t push_data,
  output logic               full,
  input  logic               pop,
  output rod_pkg::rod_item_t pop_data,
  output logic               empty
);
  import rod_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rod_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/rod_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rod_back
// Compares each frame with the shown digits, keeps the display state and
// issues one redraw transaction per place that needs it.
// ----------------------------------------------------------------------------
module rod_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  rod_pkg::rod_item_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rod_pkg::rod_out_t  out_data
);
  import rod_pkg::*;

  rod_digits_t             shown_r;
  logic [NUM_PLACES-1:0]   was_roll_r;
  rod_item_t               act_r;
  logic [NUM_PLACES-1:0]   mask_r;
  logic                    out_valid_r;
  rod_out_t                out_r;

  logic                    out_free;
  logic                    emit_fire;
  logic [POS_W-1:0]        sel;
  logic [NUM_PLACES-1:0]   rest;
  logic [NUM_PLACES-1:0]   head_mask;
  logic [DIG_W-1:0]        sel_dig;
  rod_out_t                out_nxt;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = out_free && (mask_r != '0);
  assign pop       = !empty && ((mask_r == '0) || (emit_fire && (rest == '0)));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sel = '0;
    for (int i = NUM_PLACES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = POS_W'(i);
      end
    end
    rest = mask_r;
    rest[sel] = 1'b0;
    for (int i = 0; i < NUM_PLACES; i++) begin
      head_mask[i] = (head.digits[i] != shown_r[i]) || head.roll[i] || was_roll_r[i];
    end
  end

  always_comb begin
    sel_dig                = act_r.digits[sel];
    out_nxt.digit_position = sel;
    out_nxt.digit_value    = sel_dig;
    out_nxt.next_digit     = (sel_dig == DIGIT_NINE) ? DIGIT_ZERO : sel_dig + 1'b1;
    out_nxt.rolling        = act_r.roll[sel];
    out_nxt.roll_offset    = act_r.roll[sel] ? act_r.offset : '0;
    out_nxt.inverted       = (sel < POS_W'(INVERT_PLACES));
    out_nxt.last           = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= {NUM_PLACES{DIGIT_BLANK}};
      was_roll_r  <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mask_r     <= head_mask;
        shown_r    <= head.digits;
        was_roll_r <= head.roll;
      end else if (emit_fire) begin
        mask_r <= rest;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      act_r <= head;
    end
    if (emit_fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/rolling_odometer_digit_updater.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_odometer_digit_updater
// Turns hour meter frames into per-digit redraw commands for a rolling
// six-digit odometer display.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in_*      input      in_valid / in_stall    rod_in_t  (count, fraction)
// out_*     output     out_valid / out_stall  rod_out_t (one redraw command)
//
// A frame transaction can be taken every cycle while in_stall is low into
// an 11-stage front pipeline; the back issues one redraw per cycle while
// out_stall is low, and takes the next frame along with a frame's last redraw,
// or at once when nothing needs redrawing. Frames reach the back via the queue.
// Reset is synchronous and active low; it empties the pipeline and queue,
// marks every place as blank and clears the roll flags. No clearing pass.
// in_stall rises only when the queue is full and the last front stage holds
// a frame; out_stall only holds the output register and lets the queue fill.
//
module rolling_odometer_digit_updater #(
  parameter int QUEUE_DEPTH = rod_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rod_pkg::rod_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rod_pkg::rod_out_t out_data
);
  import rod_pkg::*;

  `include "rolling_odometer_digit_updater_defines.svh"

  // Front to queue: a classified frame with its digits, roll flags and offset.
  logic      fifo_push;
  logic      fifo_full;
  rod_item_t fifo_wdata;

  // Queue to back: the oldest classified frame.
  logic      fifo_pop;
  logic      fifo_empty;
  rod_item_t fifo_rdata;

  // The front works out the six digits of the count modulo one million and
  // the roll state, independent of what the display currently shows.
  rod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (fifo_push),
    .push_data (fifo_wdata),
    .full      (fifo_full)
  );

  // The queue lets the front keep taking frames while the back is busy
  // emitting several redraws for an earlier frame.
  rod_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data (fifo_wdata),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (fifo_rdata),
    .empty     (fifo_empty)
  );

  // The back owns the shown digits and the roll flags of the previous frame.
  // It updates them when it picks up a frame and then walks the places that
  // need a redraw, most significant first.
  rod_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (fifo_empty),
    .head      (fifo_rdata),
    .pop       (fifo_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A redraw marked rolling always carries a nonzero shift.
  `ROD_ASSERT_SAME(a_roll_has_offset, out_valid && out_data.rolling, out_data.roll_offset != '0, "rolling redraw with zero offset")
  // The front never writes into a full queue.
  `ROD_ASSERT_SAME(a_no_overflow, fifo_push, !fifo_full, "push into full queue")
  // The back never takes a frame from an empty queue.
  `ROD_ASSERT_SAME(a_no_underflow, fifo_pop, !fifo_empty, "pop from empty queue")
  // A push into an empty queue leaves a frame for the back next cycle.
  `ROD_ASSERT_NEXT(a_push_lands, fifo_push && fifo_empty && !fifo_pop, !fifo_empty, "pushed frame lost")

endmodule
